// ===== sv/boost_pwm_voltage_regulator_defines.svh =====
// assertion macros for the regulator checker
`ifndef BOOST_PWM_VOLTAGE_REGULATOR_DEFINES_SVH
`define BOOST_PWM_VOLTAGE_REGULATOR_DEFINES_SVH

// property must hold at every clock edge outside reset
`define BPVR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// condition must never be seen outside reset
`define BPVR_ASSERT_NEVER(label, clk, rst, cond, msg) \
   `BPVR_ASSERT(label, clk, rst, !(cond), msg)

`endif

// ===== sv/bpvr_pkg.sv =====
// types and constants of the boost pwm voltage regulator
package bpvr_pkg;

   localparam int unsigned MAX_ATTEMPTS_DEFAULT = 20;
   localparam int unsigned ATTEMPT_W            = 5;

   localparam int unsigned REQ_DATA_W  = 32;
   localparam int unsigned RSP_DATA_W  = 24;
   localparam int unsigned CSR_ADDR_W  = 5;
   localparam int unsigned CSR_DATA_W  = 32;

   // voltages in q5.8
   localparam logic [12:0] V_FIVE  = 13'd1280;
   localparam logic [12:0] V_CLOSE = 13'd51;
   localparam logic [12:0] V_LOW   = 13'd2176;
   localparam logic [12:0] V_HIGH  = 13'd3584;

   // reciprocals in q0.16 for the small divides
   localparam logic [13:0] RECIP_TEN  = 14'd6554;
   localparam logic [13:0] RECIP_FIVE = 14'd13108;

   localparam logic [11:0] GAIN_UNLOADED_RST   = 12'd666;
   localparam logic [14:0] OFFSET_UNLOADED_RST = 15'd4096;
   localparam logic [11:0] GAIN_LOADED_RST     = 12'd1434;
   localparam logic [14:0] OFFSET_LOADED_RST   = 15'd8960;
   localparam logic [1:0]  LOOP_MODE_RST       = 2'd2;
   localparam logic [15:0] ADC_PER_VOLT_RST    = 16'd16699;

   typedef enum logic [2:0] {
      ST_SKIP       = 3'd0,
      ST_CLOSE      = 3'd1,
      ST_RANGE      = 3'd2,
      ST_STEPSTART  = 3'd3,
      ST_CONTINUOUS = 3'd4,
      ST_ADJUSTED   = 3'd5,
      ST_FINISHED   = 3'd6,
      ST_IGNORED    = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      REG_GAIN_UNLOADED   = 3'd0,
      REG_OFFSET_UNLOADED = 3'd1,
      REG_GAIN_LOADED     = 3'd2,
      REG_OFFSET_LOADED   = 3'd3,
      REG_LOOP_MODE       = 3'd4,
      REG_ADC_PER_VOLT    = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_MUL_UNLOADED,
      S_MUL_LOADED,
      S_MUL_ADC,
      S_START_END,
      S_MUL_ERR,
      S_MUL_RECIP,
      S_UPDATE,
      S_DONE
   } state_type;

endpackage

// ===== sv/boost_pwm_voltage_regulator.sv =====
// a word passes the check and done states: skip, close, range, ignored and finished
// directly, an adjustment via the error, reciprocal and update states, a start via
// the three start products and the start-end state. one word at a time, with a
// single shared 15x17 multiplier used in turn by the sequencer; req_tready is high
// only while the sequencer idles. reset (synchronous, active high) restores the
// register defaults and the idle regulation state; no clearing pass is needed.
module boost_pwm_voltage_regulator #(
   parameter int unsigned MaxAttempts = bpvr_pkg::MAX_ATTEMPTS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [12:0] target_voltage, [25:13] measured_voltage, [31:26] zero
   input  logic [bpvr_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [0] mode
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [6:0] pwm_unloaded, [13:7] pwm_loaded, [23:14] adc_setpoint
   output logic [bpvr_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // [2:0] status
   output logic [2:0]                         rsp_tuser,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [bpvr_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [bpvr_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [bpvr_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import bpvr_pkg::*;

   // configuration registers
   logic [11:0]   gain_u_ff;
   logic [14:0]   off_u_ff;
   logic [11:0]   gain_l_ff;
   logic [14:0]   off_l_ff;
   logic [1:0]    loop_mode_ff;
   logic [15:0]   adc_per_volt_ff;
   csr_index_type csr_index;

   // sequencer and regulation state
   state_type             state_ff, state_in;
   logic                  mode_ff, mode_in;
   logic [12:0]           tgt_ff, tgt_in;
   logic [12:0]           meas_ff, meas_in;
   logic signed [31:0]    prod_ff;
   logic signed [10:0]    step_ff, step_in;
   logic                  regulating_ff, regulating_in;
   logic [6:0]            duty_ff, duty_in;
   logic [6:0]            duty_l_ff, duty_l_in;
   logic [12:0]           goal_ff, goal_in;
   logic [ATTEMPT_W-1:0]  attempts_ff, attempts_in;
   logic [1:0]            rev_left_ff, rev_left_in;
   logic signed [7:0]     raw_step_ff, raw_step_in;
   logic signed [7:0]     prev_step_ff, prev_step_in;

   // staged result and output register
   status_type            res_status_ff, res_status_in;
   logic [6:0]            res_pu_ff, res_pu_in;
   logic [6:0]            res_pl_ff, res_pl_in;
   logic [9:0]            res_adc_ff, res_adc_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_load;
   logic [2:0]            rsp_status_ff;
   logic [6:0]            rsp_pu_ff;
   logic [6:0]            rsp_pl_ff;
   logic [9:0]            rsp_adc_ff;

   // shared multiplier
   logic signed [14:0]    mul_a;
   logic [15:0]           mul_b;
   logic signed [31:0]    mul_p;

   // datapath helpers
   logic signed [13:0]    dstart;
   logic [13:0]           dstart_abs;
   logic signed [13:0]    err;
   logic [13:0]           err_abs;
   logic signed [31:0]    xu;
   logic signed [31:0]    xl;
   logic signed [31:0]    round_sum;
   logic [15:0]           adc_q;
   logic [9:0]            adc_sat;
   logic signed [10:0]    step_now;
   logic [12:0]           recip_x;
   logic [10:0]           neg_step;
   logic [8:0]            quot;
   logic signed [9:0]     app;
   logic signed [10:0]    duty_sum;
   logic [6:0]            duty_new;
   logic signed [7:0]     prev_new;
   logic signed [7:0]     raw_new;
   logic                  rev;
   logic                  loop_end;

   function automatic logic [6:0] clamp_pwm(input logic signed [31:0] x);
      logic signed [15:0] f;
      f = x[31:16];
      if (f < 16'sd0) begin
         return 7'd0;
      end else if (f > 16'sd100) begin
         return 7'd100;
      end
      return f[6:0];
   endfunction

   // ---------------------------------------------------------------- csr port
   assign csr_index  = csr_index_type'(csr_paddr[4:2]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_u_ff       <= GAIN_UNLOADED_RST;
         off_u_ff        <= OFFSET_UNLOADED_RST;
         gain_l_ff       <= GAIN_LOADED_RST;
         off_l_ff        <= OFFSET_LOADED_RST;
         loop_mode_ff    <= LOOP_MODE_RST;
         adc_per_volt_ff <= ADC_PER_VOLT_RST;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         case (csr_index)
            REG_GAIN_UNLOADED:   gain_u_ff       <= csr_pwdata[11:0];
            REG_OFFSET_UNLOADED: off_u_ff        <= csr_pwdata[14:0];
            REG_GAIN_LOADED:     gain_l_ff       <= csr_pwdata[11:0];
            REG_OFFSET_LOADED:   off_l_ff        <= csr_pwdata[14:0];
            REG_LOOP_MODE:       loop_mode_ff    <= csr_pwdata[1:0];
            REG_ADC_PER_VOLT:    adc_per_volt_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_GAIN_UNLOADED:   csr_prdata = {20'd0, gain_u_ff};
         REG_OFFSET_UNLOADED: csr_prdata = {17'd0, off_u_ff};
         REG_GAIN_LOADED:     csr_prdata = {20'd0, gain_l_ff};
         REG_OFFSET_LOADED:   csr_prdata = {17'd0, off_l_ff};
         REG_LOOP_MODE:       csr_prdata = {30'd0, loop_mode_ff};
         REG_ADC_PER_VOLT:    csr_prdata = {16'd0, adc_per_volt_ff};
         default:             csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- datapath
   assign mul_p = mul_a * $signed({1'b0, mul_b});

   assign dstart     = $signed({1'b0, meas_ff}) - $signed({1'b0, tgt_ff});
   assign dstart_abs = dstart[13] ? 14'(-dstart) : dstart;
   assign err        = $signed({1'b0, goal_ff}) - $signed({1'b0, meas_ff});
   assign err_abs    = err[13] ? 14'(-err) : err;

   assign xu = prod_ff - $signed({9'd0, off_u_ff, 8'd0});
   assign xl = prod_ff - $signed({9'd0, off_l_ff, 8'd0}) - 32'sd32768;

   // rounding add shared by the adc setpoint and the error step
   assign round_sum = prod_ff + 32'sd32768;
   assign adc_q     = round_sum[31:16];
   assign adc_sat   = (adc_q > 16'd1023) ? 10'd1023 : adc_q[9:0];
   assign step_now  = round_sum[26:16];

   assign recip_x  = {step_now[9:0], 3'b000} + 13'd5;
   assign neg_step = 11'(-step_now);

   // applied step from the reciprocal product
   assign quot = prod_ff[24:16];
   always_comb begin
      if (!step_ff[10]) begin
         app = $signed({1'b0, quot});
      end else if (step_ff < -11'sd5) begin
         app = -$signed({1'b0, quot});
      end else begin
         app = -10'sd1;
      end
   end

   assign duty_sum = $signed({4'b0000, duty_ff}) + 11'(app);
   assign duty_new = (duty_sum < 11'sd5)  ? 7'd5  :
                     (duty_sum > 11'sd70) ? 7'd70 : duty_sum[6:0];
   assign prev_new = (app > 10'sd127)  ? 8'sd127  :
                     (app < -10'sd128) ? -8'sd128 : app[7:0];
   assign raw_new  = (step_ff > 11'sd127)  ? 8'sd127  :
                     (step_ff < -11'sd128) ? -8'sd128 : step_ff[7:0];
   assign rev = (app == 10'sd0) || (prev_step_ff == 8'sd0) ||
                ((app > 10'sd0) != (prev_step_ff > 8'sd0));

   assign loop_end = (err_abs <= 14'(V_CLOSE)) || (raw_step_ff == 8'sd0) ||
                     (attempts_ff >= ATTEMPT_W'(MaxAttempts)) ||
                     (duty_ff <= 7'd5) || (duty_ff >= 7'd70) || (rev_left_ff == 2'd0);

   // ---------------------------------------------------------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         regulating_ff <= 1'b0;
         duty_ff       <= 7'd0;
         duty_l_ff     <= 7'd0;
         goal_ff       <= 13'd0;
         attempts_ff   <= '0;
         rev_left_ff   <= 2'd2;
         raw_step_ff   <= 8'sd2;
         prev_step_ff  <= 8'sd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         regulating_ff <= regulating_in;
         duty_ff       <= duty_in;
         duty_l_ff     <= duty_l_in;
         goal_ff       <= goal_in;
         attempts_ff   <= attempts_in;
         rev_left_ff   <= rev_left_in;
         raw_step_ff   <= raw_step_in;
         prev_step_ff  <= prev_step_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      tgt_ff        <= tgt_in;
      meas_ff       <= meas_in;
      prod_ff       <= mul_p;
      step_ff       <= step_in;
      res_status_ff <= res_status_in;
      res_pu_ff     <= res_pu_in;
      res_pl_ff     <= res_pl_in;
      res_adc_ff    <= res_adc_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_pu_ff     <= res_pu_ff;
         rsp_pl_ff     <= res_pl_ff;
         rsp_adc_ff    <= res_adc_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      tgt_in        = tgt_ff;
      meas_in       = meas_ff;
      step_in       = step_ff;
      regulating_in = regulating_ff;
      duty_in       = duty_ff;
      duty_l_in     = duty_l_ff;
      goal_in       = goal_ff;
      attempts_in   = attempts_ff;
      rev_left_in   = rev_left_ff;
      raw_step_in   = raw_step_ff;
      prev_step_in  = prev_step_ff;
      res_status_in = res_status_ff;
      res_pu_in     = res_pu_ff;
      res_pl_in     = res_pl_ff;
      res_adc_in    = res_adc_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_load      = 1'b0;
      req_tready    = 1'b0;
      mul_a         = '0;
      mul_b         = '0;

      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               mode_in  = req_tuser;
               tgt_in   = req_tdata[12:0];
               meas_in  = req_tdata[25:13];
               state_in = S_CHECK;
            end
         end

         S_CHECK: begin
            res_pu_in  = 7'd0;
            res_pl_in  = 7'd0;
            res_adc_in = 10'd0;
            state_in   = S_DONE;
            if (!mode_ff) begin
               // any start word ends an ongoing regulation
               regulating_in = 1'b0;
               if (tgt_ff < V_FIVE) begin
                  res_status_in = ST_SKIP;
               end else if (dstart_abs <= 14'(V_CLOSE)) begin
                  res_status_in = ST_CLOSE;
               end else if (tgt_ff > V_HIGH || tgt_ff < V_LOW) begin
                  res_status_in = ST_RANGE;
               end else begin
                  state_in = S_MUL_UNLOADED;
               end
            end else if (!regulating_ff) begin
               res_status_in = ST_IGNORED;
            end else if (loop_end) begin
               res_status_in = ST_FINISHED;
               regulating_in = 1'b0;
               res_pu_in     = duty_ff;
               res_pl_in     = duty_l_ff;
            end else begin
               state_in = S_MUL_ERR;
            end
         end

         S_MUL_UNLOADED: begin
            mul_a    = $signed({2'b00, tgt_ff});
            mul_b    = {4'd0, gain_u_ff};
            state_in = S_MUL_LOADED;
         end

         S_MUL_LOADED: begin
            res_pu_in = clamp_pwm(xu);
            mul_a     = $signed({2'b00, tgt_ff});
            mul_b     = {4'd0, gain_l_ff};
            state_in  = S_MUL_ADC;
         end

         S_MUL_ADC: begin
            res_pl_in = clamp_pwm(xl);
            mul_a     = $signed({2'b00, tgt_ff});
            mul_b     = adc_per_volt_ff;
            state_in  = S_START_END;
         end

         S_START_END: begin
            state_in = S_DONE;
            // loop modes 0 and 1 both run continuous
            if (loop_mode_ff > 2'd1) begin
               res_status_in = ST_STEPSTART;
               regulating_in = 1'b1;
               duty_in       = res_pu_ff;
               duty_l_in     = res_pl_ff;
               goal_in       = tgt_ff;
               attempts_in   = '0;
               rev_left_in   = 2'd2;
               raw_step_in   = 8'sd2;
               prev_step_in  = 8'sd0;
            end else begin
               res_status_in = ST_CONTINUOUS;
               res_adc_in    = adc_sat;
            end
         end

         S_MUL_ERR: begin
            mul_a    = 15'(err);
            mul_b    = {4'd0, gain_u_ff};
            state_in = S_MUL_RECIP;
         end

         S_MUL_RECIP: begin
            step_in  = step_now;
            state_in = S_UPDATE;
            if (!step_now[10]) begin
               mul_a = $signed({2'b00, recip_x});
               mul_b = {2'b00, RECIP_TEN};
            end else if (step_now < -11'sd5) begin
               mul_a = $signed({4'b0000, neg_step});
               mul_b = {2'b00, RECIP_FIVE};
            end
         end

         S_UPDATE: begin
            // the first adjustment never counts as a reversal
            if (attempts_ff != '0 && rev && rev_left_ff != 2'd0) begin
               rev_left_in = rev_left_ff - 2'd1;
            end
            attempts_in   = attempts_ff + 1'b1;
            prev_step_in  = prev_new;
            raw_step_in   = raw_new;
            duty_in       = duty_new;
            res_status_in = ST_ADJUSTED;
            res_pu_in     = duty_new;
            res_pl_in     = duty_l_ff;
            state_in      = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {rsp_adc_ff, rsp_pl_ff, rsp_pu_ff};

endmodule

// ===== sv/bpvr_checker.sv =====
// port-level checks for the boost pwm voltage regulator and their bind
`include "boost_pwm_voltage_regulator_defines.svh"

module bpvr_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [bpvr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [2:0]                       rsp_tuser
);
   import bpvr_pkg::*;

   // a stalled result word keeps its contents
   `BPVR_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result word changed while stalled")

   // one word at a time: the sequencer is busy right after an accept
   `BPVR_ASSERT(a_busy_after_accept, clock, reset, req_tvalid && req_tready |=> !req_tready, "input accepted twice in a row")

   `BPVR_ASSERT_NEVER(a_ignored_zero, clock, reset, rsp_tvalid && rsp_tuser == ST_IGNORED && rsp_tdata != '0, "ignored word carries data")

   `BPVR_ASSERT_NEVER(a_pwm_range, clock, reset, rsp_tvalid && (rsp_tdata[6:0] > 7'd100 || rsp_tdata[13:7] > 7'd100), "pwm above 100")

   // only the continuous answer carries an adc setpoint
   `BPVR_ASSERT_NEVER(a_adc_only_cont, clock, reset, rsp_tvalid && rsp_tuser != ST_CONTINUOUS && rsp_tdata[23:14] != 10'd0, "adc setpoint outside continuous mode")

endmodule

bind boost_pwm_voltage_regulator bpvr_checker u_bpvr_checker (.*);
